FILE: sv/smdil_pkg.sv
// Shared types, constants and helpers for the 5x5 separable max dilation block.
// No dependencies; imported by the interfaces and the top level.
package smdil_pkg;

  localparam int PIX_W     = 8;   // grayscale pixel width
  localparam int CFG_W     = 12;  // width of frame_width / frame_height
  localparam int CFG_IDX_W = 1;   // register index width

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  // request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int MAX_WIDTH_DEF    = 2048;
  localparam int MAX_HEIGHT_DEF   = 2048;
  localparam int MIN_DIM          = 5;
  localparam int RST_FRAME_WIDTH  = 640;
  localparam int RST_FRAME_HEIGHT = 480;

  localparam int WIN_TAPS       = 5;  // filter span per pass
  localparam int EDGE_PX        = 2;  // pixels on each side kept as they come in
  localparam int NUM_LINES      = 4;  // line-store rows
  localparam int OUT_FIFO_DEPTH = 4;  // result buffer entries

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
  } out_item_t;

  function automatic logic [PIX_W-1:0] max_px(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: sv/smdil_if.sv
// Stream interfaces for the pixel input and the dilated result channel.
// Depends on smdil_pkg for field widths.
interface smdil_in_if
  import smdil_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output req_type, output pixel_in, input ready);
  modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface smdil_out_if
  import smdil_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             end_of_frame;

  modport source (output valid, output pixel_out, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_out, input end_of_frame, output ready);
endinterface

FILE: sv/smdil_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-before-write on an address collision. No dependencies.
module smdil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/separable_max_dilation_5x5.sv
// Top level of the 5x5 separable grayscale max dilation (row pass, then column pass).
// Depends on smdil_pkg, smdil_in_if / smdil_out_if and smdil_ram (line-store banks).
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ------------------------------------------
//  in_px     in   valid/ready        req_type (1b), pixel_in (8b)
//  out_px    out  valid/ready        pixel_out (8b), end_of_frame (1b)
//  cfg_*     in   cfg_we, no ready   cfg_index (1b), cfg_data (12b)
//
//  - One transaction per clock while in_px.ready holds; it does not depend on out_px.ready.
//  - Path: accept -> input register -> line-store read -> result buffer; a result
//    shows on out_px once it reaches the result buffer.
//  - in_px.ready drops only when the 4-entry result buffer plus the two items in
//    flight would fill it, i.e. after out_px has stalled.
//  - rst_n is synchronous; counters, window and buffer pointers clear, the line
//    store is not cleared (every entry is written before it is read).
module separable_max_dilation_5x5
  import smdil_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  smdil_in_if.sink             in_px,
  smdil_out_if.source          out_px,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);          // column index
  localparam int WW  = $clog2(MAX_WIDTH + 1);      // width value
  localparam int RW  = $clog2(MAX_HEIGHT);         // row index
  localparam int HW  = $clog2(MAX_HEIGHT + 1);     // height value
  localparam int OWW = $clog2(2 * MAX_WIDTH + 2);  // row-pass values awaiting output
  localparam int SW  = $clog2(NUM_LINES);          // line slot
  localparam int TW  = $clog2(WIN_TAPS);           // window tap index
  localparam int FPW = $clog2(OUT_FIFO_DEPTH);
  localparam int FCW = $clog2(OUT_FIFO_DEPTH + 1);

  // row pass lags its pixel by this many pixels (center plus two to the right)
  localparam logic [1:0] HP_LAG = 2'(EDGE_PX + 1);

  localparam int W_RST_I = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int H_RST_I = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [RW-1:0] row;
  } pos_t;

  // ---------------------------------------------------------------- helpers
  function automatic logic [WW-1:0] clamp_w(input logic [CFG_W-1:0] v);
    int unsigned ve;
    ve = 32'(v);
    if (ve < MIN_DIM) return WW'(MIN_DIM);
    if (ve > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(ve);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_W-1:0] v);
    int unsigned ve;
    ve = 32'(v);
    if (ve < MIN_DIM) return HW'(MIN_DIM);
    if (ve > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    return HW'(ve);
  endfunction

  function automatic logic col_end(input logic [CW-1:0] col, input logic [WW-1:0] w);
    return (WW'(col) + WW'(1)) >= w;
  endfunction

  function automatic logic row_end(input logic [RW-1:0] row, input logic [HW-1:0] h);
    return (HW'(row) + HW'(1)) >= h;
  endfunction

  // raster step; wraps to the frame origin after the last pixel
  function automatic pos_t pos_step(input pos_t p, input logic [WW-1:0] w,
                                    input logic [HW-1:0] h);
    pos_t q;
    q = p;
    if (col_end(p.col, w)) begin
      q.col = '0;
      q.row = row_end(p.row, h) ? '0 : p.row + RW'(1);
    end else begin
      q.col = p.col + CW'(1);
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- config
  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= WW'(W_RST_I);
      h_r <= HW'(H_RST_I);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  w_r <= clamp_w(cfg_data);
        CFG_FRAME_HEIGHT: h_r <= clamp_h(cfg_data);
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  logic             s1_v_r, s1_v_nxt;
  logic             s1_drain_r;
  logic [PIX_W-1:0] s1_px_r;
  logic             in_fire;

  assign in_fire  = in_px.valid && in_px.ready;
  assign s1_v_nxt = in_fire;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_drain_r <= (in_px.req_type == REQ_DRAIN);
      s1_px_r    <= in_px.pixel_in;
    end
  end

  // ---------------------------------------------------------------- stage 1 state
  logic [WIN_TAPS-1:0][PIX_W-1:0] hw_r, hw_nxt;      // [0] is the newest pixel
  pos_t                           in_pos_r, in_pos_nxt;
  pos_t                           hp_pos_r, hp_pos_nxt;
  pos_t                           out_pos_r, out_pos_nxt;
  logic [SW-1:0]                  hp_slot_r, hp_slot_nxt;
  logic [SW-1:0]                  out_slot_r, out_slot_nxt;
  logic [1:0]                     hp_wait_r, hp_wait_nxt;
  logic [OWW-1:0]                 out_wait_r, out_wait_nxt;

  logic [WIN_TAPS-1:0][PIX_W-1:0] hw_a;
  logic [1:0]                     wait_a;
  logic [1:0]                     tap_off;
  logic [OWW-1:0]                 out_wait_a;
  logic                           drop, act, finish, emit;
  logic                           hp_interior, out_interior, out_eof, fwd_hit;
  logic [PIX_W-1:0]               win_max, hv;
  logic [NUM_LINES-1:0]           line_we;
  logic [NUM_LINES-1:0][PIX_W-1:0] line_rd;

  always_comb begin
    hw_a   = s1_drain_r ? hw_r : {hw_r[WIN_TAPS-2:0], s1_px_r};
    wait_a = (!s1_drain_r && hp_wait_r != HP_LAG) ? hp_wait_r + 2'd1 : hp_wait_r;

    // drain mid-frame or with nothing pending is a no-op
    drop = s1_drain_r && (in_pos_r != '0 || (hp_wait_r == '0 && out_wait_r == '0));
    act  = s1_v_r && !drop;

    finish = s1_drain_r ? (hp_wait_r != '0) : (wait_a == HP_LAG);

    hp_interior = (hp_pos_r.col >= CW'(EDGE_PX)) &&
                  ((WW'(hp_pos_r.col) + WW'(EDGE_PX)) < w_r);
    win_max = hw_a[0];
    for (int k = 1; k < WIN_TAPS; k++) begin
      win_max = max_px(win_max, hw_a[k]);
    end
    tap_off = wait_a - 2'd1;
    hv = (wait_a == HP_LAG && hp_interior) ? win_max : hw_a[TW'(tap_off)];

    out_wait_a = out_wait_r + OWW'(finish);
    emit = s1_drain_r ? (out_wait_a != '0)
                      : (out_wait_a >= ((OWW'(w_r) << 1) + OWW'(1)));

    out_interior = (out_pos_r.row >= RW'(EDGE_PX)) &&
                   ((HW'(out_pos_r.row) + HW'(EDGE_PX)) < h_r);
    out_eof      = col_end(out_pos_r.col, w_r) && row_end(out_pos_r.row, h_r);
    // this item writes the very column the output reads
    fwd_hit      = finish && (hp_pos_r.col == out_pos_r.col);

    for (int b = 0; b < NUM_LINES; b++) begin
      line_we[b] = act && finish && (hp_slot_r == SW'(b));
    end

    hw_nxt       = act ? hw_a : hw_r;
    in_pos_nxt   = (act && !s1_drain_r) ? pos_step(in_pos_r, w_r, h_r) : in_pos_r;
    hp_wait_nxt  = act ? (wait_a - 2'(finish)) : hp_wait_r;
    out_wait_nxt = act ? (out_wait_a - OWW'(emit)) : out_wait_r;

    hp_pos_nxt  = hp_pos_r;
    hp_slot_nxt = hp_slot_r;
    if (act && finish) begin
      hp_pos_nxt  = pos_step(hp_pos_r, w_r, h_r);
      hp_slot_nxt = hp_slot_r + SW'(col_end(hp_pos_r.col, w_r));
    end

    out_pos_nxt  = out_pos_r;
    out_slot_nxt = out_slot_r;
    if (act && emit) begin
      out_pos_nxt  = pos_step(out_pos_r, w_r, h_r);
      out_slot_nxt = out_slot_r + SW'(col_end(out_pos_r.col, w_r));
    end
  end

  // four line-store banks, one per row slot; all read at the output column
  for (genvar b = 0; b < NUM_LINES; b++) begin : g_line
    smdil_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (line_we[b]),
      .waddr (hp_pos_r.col),
      .wdata (hv),
      .raddr (out_pos_r.col),
      .rdata (line_rd[b])
    );
  end

  // ---------------------------------------------------------------- stage 2 regs
  logic             s2_v_r, s2_v_nxt;
  logic [SW-1:0]    s2_slot_r;
  logic             s2_interior_r;
  logic             s2_eof_r;
  logic             s2_hit_r;
  logic [SW-1:0]    s2_wbank_r;
  logic [PIX_W-1:0] s2_hv_r;

  assign s2_v_nxt = act && emit;

  always_ff @(posedge clk) begin
    s2_slot_r     <= out_slot_r;
    s2_interior_r <= out_interior;
    s2_eof_r      <= out_eof;
    s2_hit_r      <= fwd_hit;
    s2_wbank_r    <= hp_slot_r;
    s2_hv_r       <= hv;
  end

  // ---------------------------------------------------------------- column pass
  // Bank slot+2 holds both the row two above (old data) and the row two below
  // (written by the same transaction), so it is read as old and as new.
  logic [NUM_LINES-1:0][PIX_W-1:0] line_new;
  logic [SW-1:0]                   sl_up2, sl_up1, sl_dn1;
  logic [PIX_W-1:0]                col_max;
  out_item_t                       result;

  always_comb begin
    for (int b = 0; b < NUM_LINES; b++) begin
      line_new[b] = (s2_hit_r && s2_wbank_r == SW'(b)) ? s2_hv_r : line_rd[b];
    end
    sl_up2 = s2_slot_r + SW'(2);
    sl_up1 = s2_slot_r + SW'(3);
    sl_dn1 = s2_slot_r + SW'(1);

    col_max = max_px(line_rd[sl_up2], line_new[sl_up1]);
    col_max = max_px(col_max, line_new[s2_slot_r]);
    col_max = max_px(col_max, line_new[sl_dn1]);
    col_max = max_px(col_max, line_new[sl_up2]);

    result.pixel_out    = s2_interior_r ? col_max : line_new[s2_slot_r];
    result.end_of_frame = s2_eof_r;
  end

  // ---------------------------------------------------------------- result buffer
  out_item_t      fifo_mem_r [OUT_FIFO_DEPTH];
  logic [FPW-1:0] fifo_wp_r, fifo_wp_nxt;
  logic [FPW-1:0] fifo_rp_r, fifo_rp_nxt;
  logic [FCW-1:0] fifo_cnt_r, fifo_cnt_nxt;
  logic [FCW:0]   credit_used;
  logic           fifo_push, fifo_pop;

  assign fifo_push = s2_v_r;
  assign fifo_pop  = out_px.valid && out_px.ready;

  always_comb begin
    fifo_wp_nxt  = fifo_wp_r;
    fifo_rp_nxt  = fifo_rp_r;
    if (fifo_push) begin
      fifo_wp_nxt = (fifo_wp_r == FPW'(OUT_FIFO_DEPTH - 1)) ? '0 : fifo_wp_r + FPW'(1);
    end
    if (fifo_pop) begin
      fifo_rp_nxt = (fifo_rp_r == FPW'(OUT_FIFO_DEPTH - 1)) ? '0 : fifo_rp_r + FPW'(1);
    end
    fifo_cnt_nxt = fifo_cnt_r + FCW'(fifo_push) - FCW'(fifo_pop);
    // every item in flight may still produce a result
    credit_used  = (FCW + 1)'(fifo_cnt_r) + (FCW + 1)'(s1_v_r) + (FCW + 1)'(s2_v_r);
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem_r[fifo_wp_r] <= result;
    end
  end

  assign in_px.ready         = credit_used < (FCW + 1)'(OUT_FIFO_DEPTH);
  assign out_px.valid        = fifo_cnt_r != '0;
  assign out_px.pixel_out    = fifo_mem_r[fifo_rp_r].pixel_out;
  assign out_px.end_of_frame = fifo_mem_r[fifo_rp_r].end_of_frame;

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      hw_r       <= '0;
      in_pos_r   <= '0;
      hp_pos_r   <= '0;
      out_pos_r  <= '0;
      hp_slot_r  <= '0;
      out_slot_r <= '0;
      hp_wait_r  <= '0;
      out_wait_r <= '0;
      fifo_wp_r  <= '0;
      fifo_rp_r  <= '0;
      fifo_cnt_r <= '0;
    end else begin
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
      hw_r       <= hw_nxt;
      in_pos_r   <= in_pos_nxt;
      hp_pos_r   <= hp_pos_nxt;
      out_pos_r  <= out_pos_nxt;
      hp_slot_r  <= hp_slot_nxt;
      out_slot_r <= out_slot_nxt;
      hp_wait_r  <= hp_wait_nxt;
      out_wait_r <= out_wait_nxt;
      fifo_wp_r  <= fifo_wp_nxt;
      fifo_rp_r  <= fifo_rp_nxt;
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------- assertions
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_push |-> (fifo_cnt_r < FCW'(OUT_FIFO_DEPTH)) || fifo_pop)
    else $error("result buffer overflow");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= (FCW + 1)'(OUT_FIFO_DEPTH))
    else $error("more results in flight than buffer entries");

  a_one_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(line_we))
    else $error("row-pass value written to more than one bank");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> $past(s1_v_r))
    else $error("result without an accepted transaction");

  a_row_pass_lag: assert property (@(posedge clk) disable iff (!rst_n)
    hp_wait_r != HP_LAG)
    else $error("row pass fell behind the window");

endmodule

FILE: test/tb.sv
// Self-checking testbench for separable_max_dilation_5x5: 5x5 grayscale max dilation.
// Needs smdil_pkg, smdil_in_if / smdil_out_if and the block's RTL; reads no files.
// An in-bench predictor tracks both filter passes and checks every output transaction.
module tb;
  import smdil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {FILL_RANDOM, FILL_SPOTS, FILL_EXTREMES} fill_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  smdil_in_if in_if ();
  smdil_out_if out_if ();

  separable_max_dilation_5x5 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_if),
    .out_px    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns period
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Dilation predictor: own copy of the registers and of the filter state.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] width_reg  = RST_FRAME_WIDTH;
  logic [CFG_W-1:0] height_reg = RST_FRAME_HEIGHT;
  // four rows of row-pass (horizontal max) values, MAX_WIDTH columns each
  logic [PIX_W-1:0] row_lines [NUM_LINES*MAX_WIDTH_DEF] = '{default: '0};
  // last five pixels, newest at index 0
  logic [PIX_W-1:0] hwin [WIN_TAPS] = '{default: '0};
  int unsigned in_pos      = 0;  // pixel index inside the frame being received
  int unsigned out_pos     = 0;  // pixel index of the next dilated result
  int unsigned row_pos     = 0;  // pixel index of the next row-pass value
  int unsigned row_pending = 0;  // pixels waiting for their row-pass value
  int unsigned col_pending = 0;  // row-pass values waiting for the column pass
  int unsigned row_slot    = 0;  // line-store row being written
  int unsigned col_slot    = 0;  // line-store row of the output position

  // expected dilated pixels, oldest first
  out_item_t dilated_q [$];

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // step a raster position; the line-store slot moves on at each row start
  function automatic void step_pos(inout int unsigned pos, inout int unsigned slot,
                                   input int unsigned w, input int unsigned area);
    pos = (pos + 1 >= area) ? 0 : pos + 1;
    if (pos % w == 0) slot = (slot + 1) % NUM_LINES;
  endfunction

  // Advances the predictor by one accepted transaction; returns 1 when it yields a result.
  function automatic bit predict_dilation(input bit is_drain, input logic [PIX_W-1:0] px,
                                          output out_item_t res);
    int unsigned w, h, area, col, off, waddr, r, c, addr;
    int k;
    logic [PIX_W-1:0] hv, old_val, v, e;
    bit finish;
    res = '0;
    w = clamp_dim(width_reg, MAX_WIDTH_DEF);
    h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
    area = w * h;
    finish = 1'b0;
    waddr = 0;
    old_val = '0;

    if (!is_drain) begin
      for (k = WIN_TAPS - 1; k > 0; k--) hwin[k] = hwin[k-1];
      hwin[0] = px;
      in_pos = (in_pos + 1 >= area) ? 0 : in_pos + 1;
      if (row_pending < 3) row_pending++;
      finish = (row_pending >= 3);
    end else begin
      // drain mid-frame or with nothing pending: ignored
      if (in_pos != 0 || (row_pending == 0 && col_pending == 0)) return 1'b0;
      finish = (row_pending > 0);
    end

    // row pass: center of the window is two pixels back; edge columns pass through
    if (finish) begin
      col = row_pos % w;
      off = (row_pending - 1 > 4) ? 4 : row_pending - 1;
      if (row_pending >= 3 && col >= EDGE_PX && col + EDGE_PX < w) begin
        hv = hwin[0];
        for (k = 1; k < WIN_TAPS; k++) if (hwin[k] > hv) hv = hwin[k];
      end else begin
        hv = hwin[off];
      end
      waddr = row_slot * MAX_WIDTH_DEF + col;
      old_val = row_lines[waddr];
      row_lines[waddr] = hv;
      row_pending--;
      col_pending++;
      step_pos(row_pos, row_slot, w, area);
    end

    if (is_drain ? (col_pending == 0) : (col_pending < 2 * w + 1)) return 1'b0;

    // column pass: rows r-2..r+2; the slot just overwritten still counts as row r-2
    r = out_pos / w;
    c = out_pos % w;
    if (r >= EDGE_PX && r + EDGE_PX < h) begin
      v = '0;
      for (k = 0; k < WIN_TAPS; k++) begin
        addr = ((col_slot + k + 2) % NUM_LINES) * MAX_WIDTH_DEF + c;
        e = row_lines[addr];
        if (k == 0 && finish && addr == waddr) e = old_val;
        if (e > v) v = e;
      end
    end else begin
      v = row_lines[col_slot * MAX_WIDTH_DEF + c];
    end
    res.pixel_out = v;
    res.end_of_frame = (out_pos + 1 >= area);
    col_pending--;
    step_pos(out_pos, col_slot, w, area);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Run state and counters
  // ---------------------------------------------------------------------------
  int src_idle_pct   = 0;  // chance per cycle that the sender idles
  int sink_stall_pct = 0;  // chance per cycle that the receiver stalls
  int hold_request   = 0;  // long receiver hold-off, counted down by the receiver
  int mismatch_count = 0;
  int results_checked = 0;
  int pixel_count  = 0;
  int drain_count  = 0;    // drains that produced a result
  int ignored_count = 0;   // drains the block must ignore
  int frame_count  = 0;
  out_item_t head_item;

  // Receiver: random stalls, or a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      out_if.ready <= 1'b0;
      hold_request--;
    end else
      out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      if (dilated_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: pixel_out=%0d end_of_frame=%0b",
                   $realtime, out_if.pixel_out, out_if.end_of_frame);
      end else begin
        head_item = dilated_q.pop_front();
        if (head_item.pixel_out !== out_if.pixel_out ||
            head_item.end_of_frame !== out_if.end_of_frame) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] mismatch: pixel_out exp %0d got %0d, end_of_frame exp %0b got %0b",
                     $realtime, head_item.pixel_out, out_if.pixel_out,
                     head_item.end_of_frame, out_if.end_of_frame);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end right after a rising edge.
  // ---------------------------------------------------------------------------

  // One input transaction, with random sender idles ahead of it. valid stays high
  // afterwards so the next call can follow back to back.
  task automatic send_item(input logic req, input logic [PIX_W-1:0] px);
    out_item_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= req;
    in_if.pixel_in <= px;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (predict_dilation(req == REQ_DRAIN, px, res)) begin
      dilated_q.push_back(res);
      if (req == REQ_DRAIN) drain_count++;
    end else if (req == REQ_DRAIN) begin
      ignored_count++;
    end
    if (req == REQ_PIXEL) pixel_count++;
  endtask

  // Stop offering, let every expected result arrive, then allow for the pipeline.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (dilated_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Both registers are rewritten, always with the block idle.
  task automatic resize_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = w;
    height_reg = h;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] next_pixel(input fill_t fill, input int unsigned idx);
    case (fill)
      FILL_SPOTS:    return ($urandom_range(19) == 0) ? 8'hFF : 8'($urandom_range(7));
      FILL_EXTREMES: return ((idx % 7) == 3 || (idx % 11) == 0) ? 8'hFF : 8'h00;
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  // A whole frame at the current size; noise_pct adds mid-frame drains the block ignores.
  task automatic send_frame(input fill_t fill, input int noise_pct);
    int unsigned total, i;
    total = clamp_dim(width_reg, MAX_WIDTH_DEF) * clamp_dim(height_reg, MAX_HEIGHT_DEF);
    for (i = 0; i < total; i++) begin
      send_item(REQ_PIXEL, next_pixel(fill, i));
      if (i + 1 < total && $urandom_range(99) < noise_pct)
        send_item(REQ_DRAIN, 8'($urandom_range(255)));
    end
    frame_count++;
  endtask

  // Flush the tail of the last frame with drain transactions.
  task automatic drain_all();
    while (row_pending != 0 || col_pending != 0)
      send_item(REQ_DRAIN, 8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Smallest frame with 0/255 content; low out-of-range sizes clamp to 5x5.
  // Drains with nothing pending and drains mid-frame must be ignored.
  task automatic check_small_frame();
    resize_frame(12'd0, 12'd3);
    send_item(REQ_DRAIN, 8'hFF);
    send_frame(FILL_EXTREMES, 10);
    drain_all();
    send_item(REQ_DRAIN, 8'h00);
  endtask

  // New frames push out the previous tail, with and without a partial drain between.
  task automatic check_back_to_back();
    resize_frame(12'd6, 12'd5);
    send_frame(FILL_RANDOM, 0);
    send_frame(FILL_SPOTS, 0);
    repeat (7) send_item(REQ_DRAIN, 8'($urandom_range(255)));
    send_frame(FILL_RANDOM, 0);
    drain_all();
  endtask

  // Widest and tallest frames; 4095 in either register clamps to the maximum.
  task automatic check_size_extremes();
    resize_frame(12'd2048, 12'd5);
    send_frame(FILL_SPOTS, 0);
    drain_all();
    resize_frame(12'd4095, 12'd5);
    send_frame(FILL_RANDOM, 0);
    drain_all();
    resize_frame(12'd5, 12'd4095);
    send_frame(FILL_SPOTS, 0);
    drain_all();
  endtask

  // Long receiver hold-off while the sender keeps going, so the input stalls;
  // later the sender pauses mid-frame until every result is out.
  task automatic check_backpressure();
    int unsigned i;
    resize_frame(12'd9, 12'd7);
    for (i = 0; i < 63; i++) begin
      if (i == 20) hold_request = 120;
      if (i == 45) settle();
      send_item(REQ_PIXEL, 8'($urandom_range(255)));
    end
    frame_count++;
    drain_all();
  endtask

  // Random frames of small random size. Tails are flushed, partly flushed or
  // pushed out by the next frame; sizes change only after a full flush.
  task automatic run_random_frames(input int idle_pct, input int stall_pct, input int budget);
    int target;
    fill_t fill;
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    target = pixel_count + drain_count + budget;
    while (pixel_count + drain_count < target) begin
      case ($urandom_range(2))
        0:       fill = FILL_SPOTS;
        1:       fill = FILL_EXTREMES;
        default: fill = FILL_RANDOM;
      endcase
      send_frame(fill, ($urandom_range(3) == 0) ? 5 : 0);
      case ($urandom_range(3))
        0: ;  // next frame pushes the tail out
        1: repeat ($urandom_range(row_pending + col_pending))
             send_item(REQ_DRAIN, 8'($urandom_range(255)));
        default: begin
          drain_all();
          if ($urandom_range(1))
            resize_frame(($urandom_range(9) == 0) ? 12'($urandom_range(4))
                                                  : 12'($urandom_range(16, 5)),
                         ($urandom_range(9) == 0) ? 12'($urandom_range(4))
                                                  : 12'($urandom_range(10, 5)));
        end
      endcase
    end
    drain_all();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int spin;
    int leftover;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_PIXEL;
    in_if.pixel_in = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_small_frame();
    check_back_to_back();
    check_size_extremes();
    check_backpressure();
    run_random_frames(0, 0, 400);    // full rate
    run_random_frames(66, 0, 400);   // sender mostly idle
    run_random_frames(0, 66, 400);   // receiver mostly stalled
    run_random_frames(6, 6, 400);    // light gaps on both sides

    // wait for the last results, bounded, then wait on for any strays
    in_if.valid <= 1'b0;
    for (spin = 0; spin < 50000 && dilated_q.size() != 0; spin++) @(posedge clk);
    repeat (20) @(posedge clk);
    leftover = dilated_q.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);

    $display("covered %0d frames (5x5 up to 2048x5 and 5x2048), %0d pixel and %0d drain transactions,",
             frame_count, pixel_count, drain_count);
    $display("%0d ignored drains, %0d results checked, %0d mismatches, four idling mixes",
             ignored_count, results_checked, mismatch_count);
    if (mismatch_count == 0 && leftover == 0)
      $display("separable_max_dilation_5x5 regression: pass");
    else
      $display("separable_max_dilation_5x5 regression: fail");
    $finish;
  end

  // Hard limit well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("separable_max_dilation_5x5 regression: fail");
    $finish;
  end

endmodule
